[rtl/dof_pkg.sv]
`timescale 1ns / 1ps

package dof_pkg;

   // Fixed field widths
   localparam int DATA_W = 32;
   localparam int THR_W  = 12;
   localparam int POS_W  = 6;
   localparam int FRAC_W = 8;
   localparam int UPC_W  = 4;

   localparam logic [THR_W-1:0] THR_RESET = 12'd502;

   typedef logic [UPC_W-1:0] upc_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLR,
      OP_SUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SPREAD,
      OP_MUL_INIT,
      OP_MUL_STEP,
      OP_PROD,
      OP_TEST,
      OP_EMIT,
      OP_DONE
   } op_type;

   // Jump conditions of the sequencer
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_NOT_GO,
      COND_IDX_MORE,
      COND_DIV_MORE,
      COND_MUL_MORE,
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     wait_out;
      upc_type  target;
   } ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      logic   idle;
      op_type op;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic go;
      logic idx_last;
      logic div_last;
      logic mul_last;
      logic out_busy;
   } stat_type;

endpackage

[rtl/dof_ram.sv]
`timescale 1ns / 1ps

module dof_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dof_seq.sv]
`timescale 1ns / 1ps

module dof_seq
   import dof_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   // Program addresses
   localparam upc_type P_IDLE    = 4'd0;
   localparam upc_type P_SUM_RD  = 4'd1;
   localparam upc_type P_SUM     = 4'd2;
   localparam upc_type P_DIVI    = 4'd3;
   localparam upc_type P_DIV     = 4'd4;
   localparam upc_type P_SPR_RD  = 4'd5;
   localparam upc_type P_SPR     = 4'd6;
   localparam upc_type P_MULI    = 4'd7;
   localparam upc_type P_MUL     = 4'd8;
   localparam upc_type P_TST_RD  = 4'd9;
   localparam upc_type P_PROD    = 4'd10;
   localparam upc_type P_TEST    = 4'd11;
   localparam upc_type P_EMIT_RD = 4'd12;
   localparam upc_type P_EMIT    = 4'd13;
   localparam upc_type P_DONE    = 4'd14;

   // Control store
   function automatic ucode_type rom(input upc_type step);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, wait_out: 1'b0, target: P_IDLE};
      unique case (step)
         P_IDLE:    w = '{op: OP_CLR,      cond: COND_NOT_GO,   wait_out: 1'b0, target: P_IDLE};
         P_SUM_RD:  w = '{op: OP_NOP,      cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_SUM:     w = '{op: OP_SUM,      cond: COND_IDX_MORE, wait_out: 1'b0, target: P_SUM_RD};
         P_DIVI:    w = '{op: OP_DIV_INIT, cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_DIV:     w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, wait_out: 1'b0, target: P_DIV};
         P_SPR_RD:  w = '{op: OP_NOP,      cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_SPR:     w = '{op: OP_SPREAD,   cond: COND_IDX_MORE, wait_out: 1'b0, target: P_SPR_RD};
         P_MULI:    w = '{op: OP_MUL_INIT, cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_MUL:     w = '{op: OP_MUL_STEP, cond: COND_MUL_MORE, wait_out: 1'b0, target: P_MUL};
         P_TST_RD:  w = '{op: OP_NOP,      cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_PROD:    w = '{op: OP_PROD,     cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_TEST:    w = '{op: OP_TEST,     cond: COND_IDX_MORE, wait_out: 1'b0, target: P_TST_RD};
         P_EMIT_RD: w = '{op: OP_NOP,      cond: COND_NEXT,     wait_out: 1'b0, target: P_IDLE};
         P_EMIT:    w = '{op: OP_EMIT,     cond: COND_IDX_MORE, wait_out: 1'b1, target: P_EMIT_RD};
         P_DONE:    w = '{op: OP_DONE,     cond: COND_ALWAYS,   wait_out: 1'b0, target: P_IDLE};
         default:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   wait_out: 1'b0, target: P_IDLE};
      endcase
      return w;
   endfunction

   upc_type   upc_ff;
   upc_type   upc_in;
   ucode_type word;
   logic      hold;
   logic      take;

   // Fetch, evaluate the jump and pick the next step
   always_comb begin
      word = rom(upc_ff);
      hold = word.wait_out && stat.out_busy;
      unique case (word.cond)
         COND_NEXT:     take = 1'b0;
         COND_NOT_GO:   take = !stat.go;
         COND_IDX_MORE: take = !stat.idx_last;
         COND_DIV_MORE: take = !stat.div_last;
         COND_MUL_MORE: take = !stat.mul_last;
         COND_ALWAYS:   take = 1'b1;
         default:       take = 1'b1;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end else if (take) begin
         upc_in = word.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
      ctrl.idle = (upc_ff == P_IDLE);
      ctrl.op   = hold ? OP_NOP : word.op;
   end

   // Hold the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= P_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[rtl/dof_datapath.sv]
`timescale 1ns / 1ps

module dof_datapath
   import dof_pkg::*;
#(
   parameter int SET_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [THR_W-1:0]  threshold,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_sample,
   input  logic              req_set_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_kept_sample,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_final_res,
   output logic              rsp_overflowed
);

   localparam int IDX_W  = $clog2(SET_DEPTH);
   localparam int CNT_W  = $clog2(SET_DEPTH + 1);
   localparam int SUM_W  = DATA_W + IDX_W;
   localparam int PROD_W = DATA_W + IDX_W;
   localparam int RHS_W  = SUM_W + THR_W;
   localparam int LOOP_W = $clog2(SUM_W);

   // Control state
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LOOP_W-1:0]    loop_ff, loop_in;

   // Payload state
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [RHS_W-1:0]     rhs_ff, rhs_in;
   logic [THR_W-1:0]     thr_sh_ff, thr_sh_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [IDX_W-1:0]     lastk_ff, lastk_in;
   logic [DATA_W-1:0]    out_data_ff, out_data_in;
   logic [POS_W-1:0]     out_pos_ff, out_pos_in;
   logic                 out_final_ff, out_final_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 accept;
   logic                 ram_wr;
   logic [DATA_W-1:0]    rdata;
   logic                 keep_wr;
   logic                 keep_bit;
   logic                 keep_rd;
   logic [DATA_W-1:0]    mean;
   logic [DATA_W-1:0]    absdiff;
   logic [DATA_W-1:0]    updiff;
   logic [IDX_W-1:0]     n_m1;
   logic [IDX_W-1:0]     idx_adv;
   logic [CNT_W:0]       rem_sh;
   logic                 rem_ge;
   logic [RHS_W-1:0]     lhs;
   logic                 outlier;

   dof_ram #(
      .WIDTH(DATA_W),
      .DEPTH(SET_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_sample),
      .rd_addr (idx_ff),
      .rd_data (rdata)
   );

   // Keep flags, written in the test pass and read in the output pass
   dof_ram #(
      .WIDTH(1),
      .DEPTH(SET_DEPTH)
   ) u_keep (
      .clock   (clock),
      .wr_en   (keep_wr),
      .wr_addr (idx_ff),
      .wr_data (keep_bit),
      .rd_addr (idx_ff),
      .rd_data (keep_rd)
   );

   assign accept    = req_valid && ctrl.idle;
   assign req_stall = !ctrl.idle;
   assign ram_wr    = accept && (count_ff < CNT_W'(SET_DEPTH));
   assign keep_wr   = (ctrl.op == OP_TEST);
   assign keep_bit  = !outlier;

   assign mean    = quo_ff[DATA_W-1:0];
   assign absdiff = (rdata >= mean) ? (rdata - mean) : (mean - rdata);
   assign updiff  = (rdata > mean) ? (rdata - mean) : '0;
   assign n_m1    = IDX_W'(count_ff - CNT_W'(1));
   assign idx_adv = (idx_ff == n_m1) ? '0 : idx_ff + IDX_W'(1);
   assign rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, count_ff};
   assign lhs     = RHS_W'({prod_ff, {FRAC_W{1'b0}}});
   assign outlier = lhs > rhs_ff;

   // Status back to the sequencer
   assign stat.go       = accept && req_set_end;
   assign stat.idx_last = (idx_ff == n_m1);
   assign stat.div_last = (loop_ff == LOOP_W'(SUM_W - 1));
   assign stat.mul_last = (loop_ff == LOOP_W'(THR_W - 1));
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      loop_in      = loop_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rhs_in       = rhs_ff;
      thr_sh_in    = thr_sh_ff;
      prod_in      = prod_ff;
      lastk_in     = lastk_ff;
      out_data_in  = out_data_ff;
      out_pos_in   = out_pos_ff;
      out_final_in = out_final_ff;
      out_ovf_in   = out_ovf_ff;

      // Load: store while room is left, else flag the overflow
      if (accept) begin
         if (ram_wr) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      // Drop the output once transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_CLR: begin
            acc_in = '0;
            idx_in = '0;
         end
         OP_SUM: begin
            acc_in = acc_ff + SUM_W'(rdata);
            idx_in = idx_adv;
         end
         OP_DIV_INIT: begin
            quo_in  = acc_ff;
            rem_in  = '0;
            loop_in = '0;
            acc_in  = '0;
         end
         OP_DIV_STEP: begin
            // One quotient bit per step, restoring
            rem_in  = rem_ge ? CNT_W'(rem_sh - {1'b0, count_ff}) : CNT_W'(rem_sh);
            quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
            loop_in = loop_ff + LOOP_W'(1);
         end
         OP_SPREAD: begin
            acc_in = acc_ff + SUM_W'(absdiff);
            idx_in = idx_adv;
         end
         OP_MUL_INIT: begin
            rhs_in    = '0;
            thr_sh_in = threshold;
            loop_in   = '0;
         end
         OP_MUL_STEP: begin
            // Shift-add, threshold MSB first
            rhs_in    = {rhs_ff[RHS_W-2:0], 1'b0}
                        + (thr_sh_ff[THR_W-1] ? RHS_W'(acc_ff) : '0);
            thr_sh_in = {thr_sh_ff[THR_W-2:0], 1'b0};
            loop_in   = loop_ff + LOOP_W'(1);
         end
         OP_PROD: begin
            prod_in = PROD_W'(updiff) * PROD_W'(n_m1);
         end
         OP_TEST: begin
            if (!outlier) begin
               lastk_in = idx_ff;
            end
            idx_in = idx_adv;
         end
         OP_EMIT: begin
            if (keep_rd) begin
               rsp_valid_in = 1'b1;
               out_data_in  = rdata;
               out_pos_in   = POS_W'(idx_ff);
               out_final_in = (idx_ff == lastk_ff);
               out_ovf_in   = ovf_ff;
            end
            idx_in = idx_adv;
         end
         OP_DONE: begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         loop_ff      <= '0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         loop_ff      <= loop_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rhs_ff       <= rhs_in;
      thr_sh_ff    <= thr_sh_in;
      prod_ff      <= prod_in;
      lastk_ff     <= lastk_in;
      out_data_ff  <= out_data_in;
      out_pos_ff   <= out_pos_in;
      out_final_ff <= out_final_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_sample = out_data_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_final_res   = out_final_ff;
   assign rsp_overflowed  = out_ovf_ff;

endmodule

[rtl/deviation_outlier_filter.sv]
`timescale 1ns / 1ps

// One-sided outlier filter over a set of up to SET_DEPTH unsigned samples. Samples are
// taken one per cycle while the block is idle; req_set_end closes the set, and samples
// past SET_DEPTH are ignored and reported through rsp_overflowed. For a set of n
// samples the block then computes mean = floor(sum/n) and S = sum |x - mean|, and drops
// a sample only if x > mean and (x - mean)*(n-1)*256 > threshold_q8*S. Survivors leave
// in their original order with their index; rsp_final_res marks the last one. After the
// set_end transfer the block holds req_stall high until the sequencer is idle again. A
// microcoded sequencer runs one control word per cycle, holding an output step while
// the result side stalls, against sample and keep stores with a registered read: a
// read step and an add step per sample for the sum and for the spread, a read, a
// product and a compare step per sample for the test, a read and an emit step per
// sample for output, one quotient bit per cycle for the mean and one threshold bit per
// cycle for threshold*S.
// csr_wr_data updates threshold_q8 (reset 502, about 1.96); write it only while idle.

module deviation_outlier_filter
   import dof_pkg::*;
#(
   parameter int SET_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_sample,
   input  logic              req_set_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_kept_sample,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_final_res,
   output logic              rsp_overflowed,
   input  logic              csr_wr_en,
   input  logic [THR_W-1:0]  csr_wr_data
);

   ctrl_type         ctrl;
   stat_type         stat;
   logic [THR_W-1:0] threshold_ff;
   logic [THR_W-1:0] threshold_in;

   // Hold the threshold register
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   dof_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   dof_datapath #(
      .SET_DEPTH(SET_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .threshold       (threshold_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_set_end     (req_set_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept_sample (rsp_kept_sample),
      .rsp_position    (rsp_position),
      .rsp_final_res   (rsp_final_res),
      .rsp_overflowed  (rsp_overflowed)
   );

   // A closed set stops input on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_set_end) |=> req_stall)
      else $error("input taken right after set end");

   // A new result appears only from an output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.op == OP_EMIT))
      else $error("result loaded outside the output pass");

   // Hold a stalled result unchanged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kept_sample)
         && $stable(rsp_position) && $stable(rsp_final_res) && $stable(rsp_overflowed)))
      else $error("stalled result changed");

   // Processing never runs while the sequencer reports idle
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT || ctrl.op == OP_TEST || ctrl.op == OP_SUM) |-> req_stall)
      else $error("set processing while input open");

endmodule
